>>> hdl/pid_tagged_lru_tlb_core_assert.svh
// Assertion macros for the TLB core; empty when SYNTH is defined.
`ifndef PID_TAGGED_LRU_TLB_CORE_ASSERT_SVH
`define PID_TAGGED_LRU_TLB_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low
`define PLTLB_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pltlb assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define PLTLB_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pltlb assertion failed");
`else
`define PLTLB_ASSERT_IMP(lbl, pre, post)
`define PLTLB_ASSERT_NXT(lbl, pre, post)
`endif

`endif

>>> hdl/pltlb_pkg.sv
package pltlb_pkg;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF    = 16;
  localparam int FRAME_BITS_DEF = 8;

  // Fixed field widths
  localparam int OP_W    = 3;
  localparam int PROC_W  = 16;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 8;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_INV_PAGE = 3'd2,
    OP_INV_PROC = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXEC,
    ST_SCAN,
    ST_FILL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic fill;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_busy;
  } dp_sts_t;

endpackage

>>> hdl/pltlb_ctrl.sv
module pltlb_ctrl
  import pltlb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  dp_sts_t   sts,
  output logic      in_tready,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // Hold state, return to idle on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through match, execute and the optional replacement scan and fill
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = sts.need_scan ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    in_tready = (state_r == ST_IDLE) && !sts.out_busy;
    cmd.load  = in_tready && in_tvalid;
    cmd.exec  = (state_r == ST_EXEC);
    cmd.scan  = (state_r == ST_SCAN);
    cmd.fill  = (state_r == ST_FILL);
  end

endmodule

>>> hdl/pltlb_dp.sv
module pltlb_dp
  import pltlb_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_sts_t            sts,
  input  logic [OP_W-1:0]    in_op,
  input  logic [PROC_W-1:0]  in_proc,
  input  logic [PAGE_W-1:0]  in_page,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_hit,
  output logic [FRAME_W-1:0] out_frame,
  output logic [CNT_W-1:0]   out_hit_total,
  output logic [CNT_W-1:0]   out_miss_total
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W = $clog2(ENTRIES + 1);

  // Latched transaction
  logic [OP_W-1:0]       op_r;
  logic [PROC_W-1:0]     pid_r;
  logic [PAGE_W-1:0]     page_r;
  logic [FRAME_BITS-1:0] frm_r;
  logic [FRAME_BITS+FRAME_W-1:0] frm_ext;

  // Slot tags, valid bits and counters
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [PROC_W-1:0]  proc_r [ENTRIES];
  logic [PAGE_W-1:0]  tag_r  [ENTRIES];
  logic [USED_W-1:0]  used_r;
  logic [USED_W-1:0]  used_nxt;
  logic [STAMP_W-1:0] clock_r;
  logic [STAMP_W-1:0] clock_nxt;
  logic [CNT_W-1:0]   hits_r;
  logic [CNT_W-1:0]   hits_nxt;
  logic [CNT_W-1:0]   misses_r;
  logic [CNT_W-1:0]   misses_nxt;

  // Frame and stamp memories
  logic [FRAME_BITS-1:0] frame_mem [ENTRIES];
  logic [STAMP_W-1:0]    stamp_mem [ENTRIES];
  logic [FRAME_BITS-1:0] frame_rd_r;
  logic [STAMP_W-1:0]    stamp_rd_r;
  logic [IDX_W-1:0]      stamp_addr;
  logic                  frame_we;
  logic                  stamp_we;
  logic                  tag_we;
  logic [IDX_W-1:0]      wr_idx;

  // Tag compare and priority encode
  logic [ENTRIES-1:0] occ;
  logic [ENTRIES-1:0] pid_eq;
  logic [ENTRIES-1:0] page_eq;
  logic [ENTRIES-1:0] hit_vec;
  logic               enc_found;
  logic [IDX_W-1:0]   enc_idx;
  logic               match_found_r;
  logic [IDX_W-1:0]   match_idx_r;

  // Replacement scan
  logic [USED_W-1:0]  scan_cnt_r;
  logic [STAMP_W-1:0] min_stamp_r;
  logic [IDX_W-1:0]   min_idx_r;
  logic [IDX_W-1:0]   prev_idx;
  logic               full;

  // Result
  logic               produce;
  logic               res_hit;
  logic [FRAME_BITS+FRAME_W-1:0] res_frame_ext;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [CNT_W-1:0]   out_hits_r;
  logic [CNT_W-1:0]   out_misses_r;

  // Capture the transaction fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      pid_r  <= in_proc;
      page_r <= in_page;
      frm_r  <= frm_ext[FRAME_BITS-1:0];
    end
  end

  assign frm_ext = {{FRAME_BITS{1'b0}}, in_frame};

  // Compare every occupied slot against the latched tags
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      occ[i]     = (USED_W'(i) < used_r);
      pid_eq[i]  = (proc_r[i] == pid_r);
      page_eq[i] = (tag_r[i] == page_r);
    end
    hit_vec   = valid_r & occ & pid_eq & page_eq;
    enc_found = |hit_vec;
    enc_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) enc_idx = IDX_W'(i);
    end
  end

  // Register the first match and read its frame
  always_ff @(posedge clk) begin
    match_found_r <= enc_found;
    match_idx_r   <= enc_idx;
    frame_rd_r    <= frame_mem[enc_idx];
  end

  assign full      = (used_r == USED_W'(ENTRIES));
  assign prev_idx  = IDX_W'(scan_cnt_r - USED_W'(1));
  assign stamp_addr = (scan_cnt_r < USED_W'(ENTRIES)) ? scan_cnt_r[IDX_W-1:0] : '0;

  // An insert that misses a full TLB needs the replacement walk
  assign sts.need_scan = (op_r == OP_INSERT) && !match_found_r && full;

  // Decode the operation into state updates
  always_comb begin
    valid_nxt  = valid_r;
    used_nxt   = used_r;
    clock_nxt  = clock_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    frame_we   = 1'b0;
    stamp_we   = 1'b0;
    tag_we     = 1'b0;
    wr_idx     = match_idx_r;
    res_hit    = 1'b0;
    if (cmd.exec) begin
      unique case (op_r)
        OP_LOOKUP: begin
          if (match_found_r) begin
            clock_nxt = clock_r + STAMP_W'(1);
            stamp_we  = 1'b1;
            hits_nxt  = hits_r + CNT_W'(1);
            res_hit   = 1'b1;
          end else begin
            misses_nxt = misses_r + CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (match_found_r) begin
            clock_nxt = clock_r + STAMP_W'(1);
            stamp_we  = 1'b1;
            frame_we  = 1'b1;
          end else if (!full) begin
            clock_nxt = clock_r + STAMP_W'(1);
            stamp_we  = 1'b1;
            frame_we  = 1'b1;
            tag_we    = 1'b1;
            wr_idx    = used_r[IDX_W-1:0];
            used_nxt  = used_r + USED_W'(1);
          end
        end
        OP_INV_PAGE: begin
          valid_nxt = valid_r & ~(occ & pid_eq & page_eq);
        end
        OP_INV_PROC: begin
          valid_nxt = valid_r & ~(occ & pid_eq);
        end
        OP_CLEAR: begin
          used_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.fill) begin
      clock_nxt = clock_r + STAMP_W'(1);
      stamp_we  = 1'b1;
      frame_we  = 1'b1;
      tag_we    = 1'b1;
      wr_idx    = min_idx_r;
    end
    if (tag_we) valid_nxt[wr_idx] = 1'b1;
  end

  // Hold control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      used_r   <= '0;
      clock_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else begin
      valid_r  <= valid_nxt;
      used_r   <= used_nxt;
      clock_r  <= clock_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
    end
  end

  // Write slot tags
  always_ff @(posedge clk) begin
    if (tag_we) begin
      proc_r[wr_idx] <= pid_r;
      tag_r[wr_idx]  <= page_r;
    end
  end

  // Frame and stamp memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (frame_we) frame_mem[wr_idx] <= frm_r;
    if (stamp_we) stamp_mem[wr_idx] <= clock_nxt;
    stamp_rd_r <= stamp_mem[stamp_addr];
  end

  // Walk the stamps for the oldest slot, lowest index on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (cmd.exec) begin
      scan_cnt_r <= '0;
    end else if (cmd.scan && !sts.scan_done) begin
      scan_cnt_r <= scan_cnt_r + USED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && (scan_cnt_r != '0)) begin
      if ((scan_cnt_r == USED_W'(1)) || (stamp_rd_r < min_stamp_r)) begin
        min_stamp_r <= stamp_rd_r;
        min_idx_r   <= prev_idx;
      end
    end
  end

  assign sts.scan_done = (scan_cnt_r == USED_W'(ENTRIES));

  // Load the result register when the transaction completes
  assign produce       = (cmd.exec && !sts.need_scan) || cmd.fill;
  assign res_frame_ext = res_hit ? {{FRAME_W{1'b0}}, frame_rd_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_hit_r    <= res_hit;
      out_frame_r  <= res_frame_ext[FRAME_W-1:0];
      out_hits_r   <= hits_nxt;
      out_misses_r <= misses_nxt;
    end
  end

  assign sts.out_busy   = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_frame      = out_frame_r;
  assign out_hit_total  = out_hits_r;
  assign out_miss_total = out_misses_r;

endmodule

>>> hdl/pid_tagged_lru_tlb_core.sv
// Fully associative TLB with process-tagged entries and oldest-stamp replacement.
// One transaction is handled at a time and each gives exactly one result.
// For lookup, invalidate, clear, the spare opcodes and an insert that refreshes
// a match or fills a free slot, a transaction goes through tag compare, then
// execute, then the result register, and the next transaction is taken only
// after the last has reached the result register. An insert into a full TLB
// also walks every slot's stamp through the stamp memory's single read port to
// find the oldest before the replacement write. A result waiting in the output
// register blocks acceptance only if out_tready is still low when the block is
// otherwise idle. Hit and miss totals wrap at 32 bits; the access clock is
// expected never to wrap.
`include "pid_tagged_lru_tlb_core_assert.svh"

module pid_tagged_lru_tlb_core
  import pltlb_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // proc_id[15:0], virt_page[35:16], phys_frame[43:36]
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // frame_out[7:0], hit_total[39:8], miss_total[71:40]
  output logic [0:0]  out_tuser   // hit[0]
);

  ctrl_cmd_t          cmd;
  dp_sts_t            sts;
  logic               res_hit;
  logic [FRAME_W-1:0] res_frame;
  logic [CNT_W-1:0]   res_hits;
  logic [CNT_W-1:0]   res_misses;
  logic               in_acc;

  pltlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  pltlb_dp #(
    .ENTRIES    (ENTRIES),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_tuser),
    .in_proc        (in_tdata[15:0]),
    .in_page        (in_tdata[35:16]),
    .in_frame       (in_tdata[43:36]),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_hit        (res_hit),
    .out_frame      (res_frame),
    .out_hit_total  (res_hits),
    .out_miss_total (res_misses)
  );

  // Pack the result
  assign out_tdata = {res_misses, res_hits, res_frame};
  assign out_tuser = res_hit;

  assign in_acc = in_tvalid && in_tready;

  // One transaction in flight at a time
  `PLTLB_ASSERT_NXT(a_one_in_flight, in_acc, !in_tready)
  // Everything but insert answers without a replacement walk
  `PLTLB_ASSERT_IMP(a_fixed_latency, in_acc && (in_tuser != OP_INSERT), ##3 out_tvalid)
  // Replacement write only follows a completed stamp walk
  `PLTLB_ASSERT_IMP(a_fill_after_scan, cmd.fill, $past(sts.scan_done) && $past(cmd.scan))

endmodule

>>> verif/pid_tagged_lru_tlb_core_test.sv
`timescale 1ns / 1ps

module pid_tagged_lru_tlb_core_test;
  import pltlb_pkg::*;

  localparam int NUM_SLOTS     = ENTRIES_DEF;
  localparam int FRAME_KEEP    = FRAME_BITS_DEF;
  localparam logic [FRAME_W-1:0] FRAME_MASK = FRAME_W'((64'd1 << FRAME_KEEP) - 1);
  localparam int RANDOM_CMDS   = 750;
  localparam int CYCLE_LIMIT   = 500000;
  // slowest command: full-TLB insert walks every stamp
  localparam int DRAIN_CYCLES  = 3 * (NUM_SLOTS + 8);
  localparam int REPORT_LIMIT  = 100;
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [PROC_W-1:0]  pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
  } tlb_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // proc_id[15:0], virt_page[35:16], phys_frame[43:36]
  logic [2:0]  in_tuser = '0;   // opcode[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // frame_out[7:0], hit_total[39:8], miss_total[71:40]
  logic [0:0]  out_tuser;       // hit[0]

  pid_tagged_lru_tlb_core #(
    .ENTRIES    (NUM_SLOTS),
    .FRAME_BITS (FRAME_KEEP)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // Shadow copy of the translation buffer
  logic               tlb_valid [NUM_SLOTS];
  logic [PROC_W-1:0]  tlb_proc  [NUM_SLOTS];
  logic [PAGE_W-1:0]  tlb_page  [NUM_SLOTS];
  logic [FRAME_W-1:0] tlb_frame [NUM_SLOTS];
  logic [STAMP_W-1:0] tlb_stamp [NUM_SLOTS];
  int                 tlb_used = 0;
  logic [STAMP_W-1:0] tlb_clock = '0;
  logic [CNT_W-1:0]   lookup_hits = '0;
  logic [CNT_W-1:0]   lookup_misses = '0;

  tlb_cmd_t   pending_cmds [$];
  tlb_reply_t expected_replies [$];

  tlb_cmd_t next_cmd;
  logic     in_fire = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       calm_left = 0;
  int       fail_count = 0;
  int       cycle_count = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_proc[i]  = '0;
      tlb_page[i]  = '0;
      tlb_frame[i] = '0;
      tlb_stamp[i] = '0;
    end
  end

  // Write one slot with a fresh stamp
  task automatic tlb_place(input int slot, input tlb_cmd_t c);
    tlb_clock       = tlb_clock + 1;
    tlb_proc[slot]  = c.pid;
    tlb_page[slot]  = c.page;
    tlb_frame[slot] = c.frame & FRAME_MASK;
    tlb_stamp[slot] = tlb_clock;
    tlb_valid[slot] = 1'b1;
  endtask

  // Advance the shadow TLB by one command and give the reply it should produce
  task automatic translate_and_update(input tlb_cmd_t c, output tlb_reply_t r);
    int match_slot;
    int oldest;
    int i;
    r = '0;
    match_slot = -1;
    for (i = 0; i < tlb_used; i++) begin
      if (match_slot < 0 && tlb_valid[i] && tlb_proc[i] == c.pid && tlb_page[i] == c.page)
        match_slot = i;
    end
    case (c.op)
      OP_LOOKUP: begin
        if (match_slot >= 0) begin
          tlb_clock             = tlb_clock + 1;
          tlb_stamp[match_slot] = tlb_clock;
          lookup_hits           = lookup_hits + 1;
          r.hit                 = 1'b1;
          r.frame               = tlb_frame[match_slot];
        end else begin
          lookup_misses = lookup_misses + 1;
        end
      end
      OP_INSERT: begin
        if (match_slot >= 0) begin
          tlb_clock             = tlb_clock + 1;
          tlb_frame[match_slot] = c.frame & FRAME_MASK;
          tlb_stamp[match_slot] = tlb_clock;
        end else if (tlb_used < NUM_SLOTS) begin
          tlb_place(tlb_used, c);
          tlb_used++;
        end else begin
          // evict the smallest stamp, lowest index on ties, valid or not
          oldest = 0;
          for (i = 1; i < NUM_SLOTS; i++) begin
            if (tlb_stamp[i] < tlb_stamp[oldest])
              oldest = i;
          end
          tlb_place(oldest, c);
        end
      end
      OP_INV_PAGE: begin
        for (i = 0; i < tlb_used; i++) begin
          if (tlb_proc[i] == c.pid && tlb_page[i] == c.page)
            tlb_valid[i] = 1'b0;
        end
      end
      OP_INV_PROC: begin
        for (i = 0; i < tlb_used; i++) begin
          if (tlb_proc[i] == c.pid)
            tlb_valid[i] = 1'b0;
        end
      end
      OP_CLEAR: begin
        tlb_used = 0;
      end
      default: begin
      end
    endcase
    r.hit_total  = lookup_hits;
    r.miss_total = lookup_misses;
  endtask

  function automatic tlb_cmd_t tlb_cmd(input logic [OP_W-1:0] op, input logic [PROC_W-1:0] pid,
                                       input logic [PAGE_W-1:0] page,
                                       input logic [FRAME_W-1:0] frame);
    tlb_cmd_t c;
    c.op    = op;
    c.pid   = pid;
    c.page  = page;
    c.frame = frame;
    return c;
  endfunction

  // Append one command to the stimulus queue
  task automatic add_cmd(input tlb_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Mostly short gaps, a few long ones, none during a calm stretch
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(99);
    if (calm_left > 0 || roll < 50) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      if (fail_count < REPORT_LIMIT)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Drive commands: hold each until its transaction, then idle or advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds[0];
        pending_cmds.delete(0);
        in_tuser  <= next_cmd.op;
        in_tdata  <= {4'b0, next_cmd.frame, next_cmd.page, next_cmd.pid};
        in_tvalid <= 1'b1;
        gap_left  <= pick_idle();
        if (calm_left > 0)
          calm_left <= calm_left - 1;
        else if ($urandom_range(31) == 0)
          calm_left <= $urandom_range(80, 30);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left == 0 && $urandom_range(4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_idle();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Predict on each command transaction, check each result transaction
  always @(posedge clk) begin
    tlb_cmd_t   seen;
    tlb_reply_t pred;
    tlb_reply_t want;
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      seen.op    = in_tuser;
      seen.pid   = in_tdata[15:0];
      seen.page  = in_tdata[35:16];
      seen.frame = in_tdata[43:36];
      translate_and_update(seen, pred);
      expected_replies.insert(expected_replies.size(), pred);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $error("result transaction with no command outstanding");
        fail_count++;
      end else begin
        want = expected_replies[0];
        expected_replies.delete(0);
        check_field("hit", CNT_W'(want.hit), CNT_W'(out_tuser[0]));
        check_field("frame_out", CNT_W'(want.frame), CNT_W'(out_tdata[7:0]));
        check_field("hit_total", want.hit_total, out_tdata[39:8]);
        check_field("miss_total", want.miss_total, out_tdata[71:40]);
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [PROC_W-1:0] pid_pool [4];
    logic [PAGE_W-1:0] page_pool [6];
    tlb_cmd_t          c;
    int                roll;
    int                n;

    // Directed: field extremes, refresh, both invalidates, spare opcodes, clear
    add_cmd(tlb_cmd(OP_LOOKUP,    16'h0000, 20'h00000, 8'h00));
    add_cmd(tlb_cmd(OP_INSERT,    16'h0000, 20'h00000, 8'h00));
    add_cmd(tlb_cmd(OP_INSERT,    16'hFFFF, 20'hFFFFF, 8'hFF));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'h0000, 20'h00000, 8'hFF));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'hFFFF, 20'hFFFFF, 8'h00));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'hFFFF, 20'h00000, 8'h00));
    add_cmd(tlb_cmd(OP_INSERT,    16'hFFFF, 20'hFFFFF, 8'h5A));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'hFFFF, 20'hFFFFF, 8'h00));
    add_cmd(tlb_cmd(OP_INSERT,    16'h1234, 20'hABCDE, 8'hA5));
    add_cmd(tlb_cmd(OP_INSERT,    16'h1234, 20'h54321, 8'h3C));
    add_cmd(tlb_cmd(OP_INV_PAGE,  16'hFFFF, 20'hFFFFF, 8'h00));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'hFFFF, 20'hFFFFF, 8'h00));
    // invalidated slot stays occupied, so this one takes a new slot
    add_cmd(tlb_cmd(OP_INSERT,    16'hFFFF, 20'hFFFFF, 8'h81));
    add_cmd(tlb_cmd(OP_INV_PROC,  16'h1234, 20'hFFFFF, 8'hFF));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'h1234, 20'hABCDE, 8'h00));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'h1234, 20'h54321, 8'h00));
    add_cmd(tlb_cmd(OP_SPARE_LO,  16'hFFFF, 20'hFFFFF, 8'hFF));
    add_cmd(tlb_cmd(OP_SPARE_MID, 16'h0000, 20'h00000, 8'h00));
    add_cmd(tlb_cmd(OP_SPARE_HI,  16'h0000, 20'h00000, 8'h00));
    add_cmd(tlb_cmd(OP_CLEAR,     16'hFFFF, 20'hFFFFF, 8'hFF));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'h0000, 20'h00000, 8'h00));
    add_cmd(tlb_cmd(OP_INSERT,    16'h0000, 20'h00000, 8'h11));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'h0000, 20'h00000, 8'h00));
    add_cmd(tlb_cmd(OP_LOOKUP,    16'hFFFF, 20'hFFFFF, 8'h00));

    // Random: a small working set of tags so hits, fills and evictions are common
    for (n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 150 == 0) begin
        foreach (pid_pool[i]) pid_pool[i] = PROC_W'($urandom);
        foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom);
        pid_pool[0]  = ((n / 150) % 2 == 0) ? 16'hFFFF : 16'h0000;
        page_pool[0] = ((n / 150) % 2 == 0) ? 20'h00000 : 20'hFFFFF;
      end
      roll = $urandom_range(99);
      if (roll < 85) begin
        c.pid   = pid_pool[$urandom_range(3)];
        c.page  = page_pool[$urandom_range(5)];
        c.frame = FRAME_W'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 45)      c.op = OP_LOOKUP;
        else if (roll < 80) c.op = OP_INSERT;
        else if (roll < 89) c.op = OP_INV_PAGE;
        else if (roll < 95) c.op = OP_INV_PROC;
        else if (roll < 97) c.op = OP_CLEAR;
        else                c.op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end else begin
        // noise: any opcode, any tag
        c.op    = OP_W'($urandom_range(7));
        c.pid   = PROC_W'($urandom);
        c.page  = PAGE_W'($urandom);
        c.frame = FRAME_W'($urandom);
      end
      add_cmd(c);
    end

    // Hold reset, then release it between edges
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every command taken, every result back, then let the block settle
    while (pending_cmds.size() != 0 || in_tvalid) @(negedge clk);
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
